### hdl/nbaj_pkg.sv
// ----------------------------------------------------------------------------
// nbaj_pkg
// shared types and constants of the acceleration and jerk accumulator
// ----------------------------------------------------------------------------
package nbaj_pkg;

    // fractional bits of the Q-format position, velocity and mass inputs
    localparam int FRAC_BITS = 16;
    // shift base of the final scaling, FRAC_BITS - 82; the shift itself is SH_BASE - 3*h
    localparam int SH_BASE   = FRAC_BITS - 82;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_POS_X = 3'd0,
        REG_POS_Y = 3'd1,
        REG_POS_Z = 3'd2,
        REG_VEL_X = 3'd3,
        REG_VEL_Y = 3'd4,
        REG_VEL_Z = 3'd5,
        REG_INDEX = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [9:0]       idx;
    } t_target;

    typedef struct packed {
        logic [31:0]      mass;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [9:0]       idx;
        logic             last;
    } t_item;

    typedef struct packed {
        logic [2:0][63:0] accel;
        logic [2:0][63:0] jerk;
    } t_sums;

endpackage

### hdl/nbaj_src_if.sv
// ----------------------------------------------------------------------------
// nbaj_src_if
// source body channel: valid, ready and one source body per beat
// ----------------------------------------------------------------------------
interface nbaj_src_if;
    logic               valid;
    logic               ready;
    logic        [31:0] source_mass;
    logic signed [31:0] source_pos_x;
    logic signed [31:0] source_pos_y;
    logic signed [31:0] source_pos_z;
    logic signed [31:0] source_vel_x;
    logic signed [31:0] source_vel_y;
    logic signed [31:0] source_vel_z;
    logic         [9:0] source_index;
    logic               last_source;

    modport source (
        output valid, source_mass, source_pos_x, source_pos_y, source_pos_z,
               source_vel_x, source_vel_y, source_vel_z, source_index, last_source,
        input  ready
    );
    modport sink (
        input  valid, source_mass, source_pos_x, source_pos_y, source_pos_z,
               source_vel_x, source_vel_y, source_vel_z, source_index, last_source,
        output ready
    );
endinterface

### hdl/nbaj_res_if.sv
// ----------------------------------------------------------------------------
// nbaj_res_if
// result channel: valid, ready and the summed acceleration and jerk per beat
// ----------------------------------------------------------------------------
interface nbaj_res_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] accel_x;
    logic signed [63:0] accel_y;
    logic signed [63:0] accel_z;
    logic signed [63:0] jerk_x;
    logic signed [63:0] jerk_y;
    logic signed [63:0] jerk_z;

    modport source (
        output valid, accel_x, accel_y, accel_z, jerk_x, jerk_y, jerk_z,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, accel_z, jerk_x, jerk_y, jerk_z,
        output ready
    );
endinterface

### hdl/nbaj_mac.sv
// ----------------------------------------------------------------------------
// nbaj_mac
// shared 34x34 multiplier with limb-shifted 136 bit accumulator
// ----------------------------------------------------------------------------
module nbaj_mac
    import nbaj_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_en,
    input  logic         i_clr,
    input  logic [33:0]  i_a,
    input  logic [33:0]  i_b,
    input  logic [1:0]   i_pos,
    output logic [135:0] o_acc
);

    logic [135:0] r_acc;
    logic [67:0]  prod;
    logic [135:0] prod_sh;

    assign prod = 68'(i_a) * 68'(i_b);

    always_comb begin
        case (i_pos)
            2'd0:    prod_sh = {68'b0, prod};
            2'd1:    prod_sh = {34'b0, prod, 34'b0};
            2'd2:    prod_sh = {prod, 68'b0};
            default: prod_sh = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= (i_clr ? 136'b0 : r_acc) + prod_sh;
        end
    end

    assign o_acc = r_acc;

endmodule

### hdl/nbaj_core.sv
// ----------------------------------------------------------------------------
// nbaj_core
// sequencer: squares, normalize, sqrt, reciprocal, products and saturating sums
// ----------------------------------------------------------------------------
module nbaj_core
    import nbaj_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_item   i_item,
    input  t_target i_tgt,
    input  logic    i_out_busy,
    output logic    o_ready,
    output logic    o_emit,
    output t_sums   o_sums
);

    typedef enum logic [4:0] {
        S_IDLE, S_SQ_ISS, S_SQ_COL, S_NORM, S_SQRT, S_DIV, S_Q2_ISS, S_Q2_COL,
        S_Q3_COL, S_K_COL, S_PN_ISS, S_PN_COL, S_C_ISS, S_C_COL, S_T_ISS,
        S_T_COL, S_A_COL, S_J_COL, S_FIN, S_MUL
    } t_state;

    t_state r_state, r_ret;
    logic [1:0]  r_ax, r_pp;
    logic [4:0]  r_cnt;
    logic        r_last;
    logic [31:0] r_mass;
    logic [32:0] r_d [3];
    logic [32:0] r_v [3];
    logic [29:0] r_dn [3];
    logic [65:0] r_n;
    logic signed [7:0] r_e;
    logic [29:0] r_rem;
    logic [28:0] r_root;
    logic [29:0] r_qrem;
    logic [30:0] r_q, r_q2;
    logic [63:0] r_k, r_pn;
    logic [39:0] r_c;
    logic [40:0] r_u;
    logic [67:0] r_ma, r_mb;
    logic        r_mclr;
    logic [63:0] r_accel [3];
    logic [63:0] r_jerk [3];

    logic [135:0] acc;
    logic [33:0]  a_limb, b_limb;
    logic         mac_en;

    function automatic logic [32:0] mag33(logic [32:0] x);
        return x[32] ? 33'(-x) : x;
    endfunction

    function automatic logic [62:0] scale_sat(logic [135:0] x, logic signed [7:0] sh);
        logic [153:0] up;
        logic [135:0] dn;
        logic [62:0]  res;
        up = {18'b0, x} << sh[4:0];
        dn = x >> 7'(-sh);
        if (!sh[7]) begin
            res = (up[153:63] != '0) ? '1 : up[62:0];
        end else begin
            res = (dn[135:63] != '0) ? '1 : dn[62:0];
        end
        return res;
    endfunction

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [62:0] mag, logic neg);
        logic [63:0] b;
        logic [64:0] s;
        logic [63:0] res;
        b = neg ? 64'(-{1'b0, mag}) : {1'b0, mag};
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            res = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end else begin
            res = s[63:0];
        end
        return res;
    endfunction

    // combinational helpers
    logic signed [7:0] h, sh;
    logic [29:0] dn_next [3];
    logic [31:0] sq_rem;
    logic [31:0] sq_trial;
    logic        sq_ge;
    logic [30:0] dv_rem;
    logic        dv_ge;
    logic [32:0] d_mag, v_mag;
    logic [63:0] pn_mag, pn_term;
    logic [40:0] t_signed, u_next;
    logic [39:0] u_mag;
    logic [62:0] scaled;
    logic [63:0] accel_next, jerk_next;

    always_comb begin
        h  = r_e >>> 1;
        sh = 8'(SH_BASE) - 8'(3 * h);
        for (int i = 0; i < 3; i++) begin
            if (h[7]) begin
                dn_next[i] = 30'(64'(mag33(r_d[i])) << 5'(-h));
            end else begin
                dn_next[i] = 30'(mag33(r_d[i]) >> 5'(h));
            end
        end
        sq_rem   = {r_rem, r_n[57:56]};
        sq_trial = {1'b0, r_root, 2'b01};
        sq_ge    = sq_rem >= sq_trial;
        dv_rem   = {r_qrem, 1'b0};
        dv_ge    = dv_rem >= 31'(r_root);
        d_mag    = mag33(r_d[r_ax]);
        v_mag    = mag33(r_v[r_ax]);
        pn_mag   = r_pn[63] ? 64'(-r_pn) : r_pn;
        pn_term  = (r_d[r_ax][32] ^ r_v[r_ax][32]) ? 64'(-{2'b0, acc[61:0]})
                                                    : {2'b0, acc[61:0]};
        t_signed = (r_d[r_ax][32] ^ r_pn[63]) ? 41'(-{1'b0, acc[69:30]})
                                               : {1'b0, acc[69:30]};
        u_next   = {{8{r_v[r_ax][32]}}, r_v[r_ax]} - t_signed;
        u_mag    = 40'(r_u[40] ? 41'(-r_u) : r_u);
        scaled   = scale_sat(acc, sh);
        accel_next = sat_add(r_accel[r_ax], scaled, r_d[r_ax][32]);
        jerk_next  = sat_add(r_jerk[r_ax], scaled, r_u[40]);
    end

    // limb selection of the running multiply
    assign a_limb = r_pp[1] ? r_ma[67:34] : r_ma[33:0];
    assign b_limb = r_pp[0] ? r_mb[67:34] : r_mb[33:0];
    assign mac_en = (r_state == S_MUL);

    nbaj_mac u_mac (
        .i_clk (i_clk),
        .i_en  (mac_en),
        .i_clr (r_mclr && (r_pp == 2'd0)),
        .i_a   (a_limb),
        .i_b   (b_limb),
        .i_pos (2'(r_pp[1] + r_pp[0])),
        .o_acc (acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_ax    <= '0;
            r_pp    <= '0;
            r_cnt   <= '0;
            for (int i = 0; i < 3; i++) begin
                r_accel[i] <= '0;
                r_jerk[i]  <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_mass      <= i_item.mass;
                        r_last      <= i_item.last;
                        for (int i = 0; i < 3; i++) begin
                            r_d[i] <= {i_item.pos[i][31], i_item.pos[i]}
                                      - {i_tgt.pos[i][31], i_tgt.pos[i]};
                            r_v[i] <= {i_item.vel[i][31], i_item.vel[i]}
                                      - {i_tgt.vel[i][31], i_tgt.vel[i]};
                        end
                        r_ax    <= '0;
                        r_state <= (i_item.idx == i_tgt.idx) ? S_FIN : S_SQ_ISS;
                    end
                end
                S_SQ_ISS: begin
                    r_ma <= 68'(d_mag); r_mb <= 68'(d_mag);
                    r_mclr <= (r_ax == 2'd0); r_pp <= '0;
                    r_ret <= S_SQ_COL; r_state <= S_MUL;
                end
                S_SQ_COL: begin
                    if (r_ax != 2'd2) begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_SQ_ISS;
                    end else if (acc[65:0] == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_n     <= acc[65:0];
                        r_e     <= '0;
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (r_n[65:64] != '0) begin
                        r_n <= r_n >> 8; r_e <= r_e + 8'sd8;
                    end else if (r_n[63:58] != '0) begin
                        r_n <= r_n >> 2; r_e <= r_e + 8'sd2;
                    end else if (r_n[57:50] == '0) begin
                        r_n <= r_n << 8; r_e <= r_e - 8'sd8;
                    end else if (r_n[57:56] == '0) begin
                        r_n <= r_n << 2; r_e <= r_e - 8'sd2;
                    end else begin
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= 5'd28;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_n    <= r_n << 2;
                    r_rem  <= sq_ge ? 30'(sq_rem - sq_trial) : 30'(sq_rem);
                    r_root <= {r_root[27:0], sq_ge};
                    if (r_cnt == '0) begin
                        r_qrem  <= 30'h0800_0000;
                        r_q     <= '0;
                        r_cnt   <= 5'd30;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                S_DIV: begin
                    r_qrem <= dv_ge ? 30'(dv_rem - 31'(r_root)) : 30'(dv_rem);
                    r_q    <= {r_q[29:0], dv_ge};
                    if (r_cnt == '0) begin
                        r_state <= S_Q2_ISS;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                S_Q2_ISS: begin
                    r_ma <= 68'(r_q); r_mb <= 68'(r_q);
                    r_mclr <= 1'b1; r_pp <= '0;
                    r_ret <= S_Q2_COL; r_state <= S_MUL;
                end
                S_Q2_COL: begin
                    r_q2 <= acc[60:30];
                    r_ma <= 68'(acc[60:30]); r_mb <= 68'(r_q);
                    r_mclr <= 1'b1; r_pp <= '0;
                    r_ret <= S_Q3_COL; r_state <= S_MUL;
                end
                S_Q3_COL: begin
                    r_ma <= 68'(r_mass); r_mb <= 68'(acc[60:30]);
                    r_mclr <= 1'b1; r_pp <= '0;
                    r_ret <= S_K_COL; r_state <= S_MUL;
                end
                S_K_COL: begin
                    r_k <= acc[63:0];
                    for (int i = 0; i < 3; i++) begin
                        r_dn[i] <= dn_next[i];
                    end
                    r_pn    <= '0;
                    r_ax    <= '0;
                    r_state <= S_PN_ISS;
                end
                S_PN_ISS: begin
                    r_ma <= 68'(r_dn[r_ax]); r_mb <= 68'(v_mag);
                    r_mclr <= 1'b1; r_pp <= '0;
                    r_ret <= S_PN_COL; r_state <= S_MUL;
                end
                S_PN_COL: begin
                    r_pn <= r_pn + pn_term;
                    if (r_ax == 2'd2) begin
                        r_state <= S_C_ISS;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_PN_ISS;
                    end
                end
                S_C_ISS: begin
                    r_ma <= 68'(pn_mag); r_mb <= 68'(r_q2);
                    r_mclr <= 1'b1; r_pp <= '0;
                    r_ret <= S_C_COL; r_state <= S_MUL;
                end
                S_C_COL: begin
                    r_c     <= acc[95:56];
                    r_ax    <= '0;
                    r_state <= S_T_ISS;
                end
                S_T_ISS: begin
                    r_ma <= 68'({2'b0, r_dn[r_ax]} * 32'd3); r_mb <= 68'(r_c);
                    r_mclr <= 1'b1; r_pp <= '0;
                    r_ret <= S_T_COL; r_state <= S_MUL;
                end
                S_T_COL: begin
                    r_u  <= u_next;
                    r_ma <= 68'(r_k); r_mb <= 68'(d_mag);
                    r_mclr <= 1'b1; r_pp <= '0;
                    r_ret <= S_A_COL; r_state <= S_MUL;
                end
                S_A_COL: begin
                    r_accel[r_ax] <= accel_next;
                    r_ma <= 68'(r_k); r_mb <= 68'(u_mag);
                    r_mclr <= 1'b1; r_pp <= '0;
                    r_ret <= S_J_COL; r_state <= S_MUL;
                end
                S_J_COL: begin
                    r_jerk[r_ax] <= jerk_next;
                    if (r_ax == 2'd2) begin
                        r_state <= S_FIN;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_T_ISS;
                    end
                end
                S_FIN: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (!i_out_busy) begin
                        for (int i = 0; i < 3; i++) begin
                            r_accel[i] <= '0;
                            r_jerk[i]  <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_MUL: begin
                    r_pp <= r_pp + 2'd1;
                    if (r_pp == 2'd3) begin
                        r_state <= r_ret;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_emit  = (r_state == S_FIN) && r_last && !i_out_busy;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_sums.accel[i] = r_accel[i];
            o_sums.jerk[i]  = r_jerk[i];
        end
    end

`ifndef SYNTHESIS
    // root is normalized while the reciprocal runs
    a_root_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> r_root[28])
        else $error("sqrt result below 2^28");

    // restoring divider keeps its remainder below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_qrem < 30'(r_root)))
        else $error("divider remainder not below divisor");

    // normalized operand enters the square root
    a_norm_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT && r_cnt == 5'd28) |-> (r_n[57:56] != 2'b00))
        else $error("sqrt operand not normalized");

    // result only leaves toward a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> !$past(i_out_busy))
        else $error("emit while output register busy");
`endif

endmodule

### hdl/nbody_accel_jerk_accumulator_top.sv
// ----------------------------------------------------------------------------
// nbody_accel_jerk_accumulator_top
// acceleration and jerk on one target body, summed over a stream of sources
// ----------------------------------------------------------------------------
// a source's time from its beat to the next ready is set by one shared
//   34x34 multiplier (19 products of 4 limb passes), a 29 step bit-serial
//   square root and a 31 step restoring divider
// a source with the target's index skips to the finish, a zero distance after the squares
// a new source beat is taken only once the previous one is done; the result of
//   the last source is registered in an output register and held until taken
// reset: synchronous active low, clears targets, sums and all handshake state
module nbody_accel_jerk_accumulator_top
    import nbaj_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    nbaj_src_if.sink    i_src,
    nbaj_res_if.source  o_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    // target registers, to be written only while idle; the block itself does not enforce this
    t_target r_tgt;

    t_item   item;
    t_sums   sums;
    t_sums   r_res;
    logic    r_res_valid;
    logic    core_ready;
    logic    emit;
    logic    out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_POS_X: r_tgt.pos[0] <= i_cfg_data;
                REG_POS_Y: r_tgt.pos[1] <= i_cfg_data;
                REG_POS_Z: r_tgt.pos[2] <= i_cfg_data;
                REG_VEL_X: r_tgt.vel[0] <= i_cfg_data;
                REG_VEL_Y: r_tgt.vel[1] <= i_cfg_data;
                REG_VEL_Z: r_tgt.vel[2] <= i_cfg_data;
                REG_INDEX: r_tgt.idx    <= i_cfg_data[9:0];
                default:   ;   // unused index, write dropped
            endcase
        end
    end

    // pack the source beat
    always_comb begin
        item.mass   = i_src.source_mass;
        item.pos[0] = i_src.source_pos_x;
        item.pos[1] = i_src.source_pos_y;
        item.pos[2] = i_src.source_pos_z;
        item.vel[0] = i_src.source_vel_x;
        item.vel[1] = i_src.source_vel_y;
        item.vel[2] = i_src.source_vel_z;
        item.idx    = i_src.source_index;
        item.last   = i_src.last_source;
    end

    assign i_src.ready = core_ready;

    // output register is free when empty or drained this cycle
    assign out_busy = r_res_valid && !o_res.ready;

    nbaj_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_src.valid && core_ready),
        .i_item     (item),
        .i_tgt      (r_tgt),
        .i_out_busy (out_busy),
        .o_ready    (core_ready),
        .o_emit     (emit),
        .o_sums     (sums)
    );

    // result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (emit) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_res <= sums;
        end
    end

    assign o_res.valid   = r_res_valid;
    assign o_res.accel_x = r_res.accel[0];
    assign o_res.accel_y = r_res.accel[1];
    assign o_res.accel_z = r_res.accel[2];
    assign o_res.jerk_x  = r_res.jerk[0];
    assign o_res.jerk_y  = r_res.jerk[1];
    assign o_res.jerk_z  = r_res.jerk[2];

endmodule

### verif/nbaj_sums_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbaj_sums_checker
// predicts the acceleration and jerk sums per run and compares result beats
// ----------------------------------------------------------------------------
module nbaj_sums_checker
    import nbaj_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    nbaj_src_if         i_src,
    nbaj_res_if         i_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    localparam logic [63:0] SAT_MAG = 64'h7fff_ffff_ffff_ffff;

    logic signed [63:0] tgt_pos [3];
    logic signed [63:0] tgt_vel [3];
    logic [9:0]         tgt_idx;
    logic signed [63:0] acc_run [3];
    logic signed [63:0] jerk_run [3];
    t_sums              sums_q [$];

    // magnitude shift with saturation at 2^63-1, right shifts truncate
    function automatic logic [63:0] scale_mag(logic [127:0] x, int sh);
        logic [127:0] y;
        if (sh >= 0) begin
            if (x[127:64] != 0 || x[63:0] > (SAT_MAG >> sh)) return SAT_MAG;
            return x[63:0] << sh;
        end
        if (-sh >= 128) return 0;
        y = x >> (-sh);
        if (y[127:63] != 0) return SAT_MAG;
        return y[63:0];
    endfunction

    function automatic logic [63:0] sqrt_floor(logic [63:0] n);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [63:0] add_sat(logic signed [63:0] a,
                                                    logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
        if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return s[63:0];
    endfunction

    function automatic logic [63:0] mag(logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // one source's contribution to the running sums
    task automatic add_gravity(t_item it);
        logic signed [63:0] d [3], v [3], dn [3], u, pn;
        logic [127:0] s;
        logic [63:0] n, r, q, q2, q3, k, c, m, am, t, jm;
        int len, e, h, sh;
        pn = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = 64'(signed'(it.pos[i])) - tgt_pos[i];
            v[i] = 64'(signed'(it.vel[i])) - tgt_vel[i];
            s += 128'(mag(d[i])) * 128'(mag(d[i]));
        end
        if (s == 0) return;
        len = 0;
        for (int b = 0; b < 128; b++) if (s[b]) len = b + 1;
        e = (len % 2 == 0) ? len - 58 : len - 57;
        h = e / 2;
        n = scale_mag(s, -e);
        r = sqrt_floor(n);
        q = (64'd1 << 58) / r;
        q2 = (q * q) >> 30;
        q3 = (q2 * q) >> 30;
        k = 64'(it.mass) * q3;
        sh = FRAC_BITS - 82 - 3 * h;
        for (int i = 0; i < 3; i++) begin
            m = mag(d[i]);
            m = h >= 0 ? m >> h : m << (-h);
            dn[i] = d[i] < 0 ? -$signed(m) : $signed(m);
            pn += dn[i] * v[i];
        end
        c = scale_mag(128'(mag(pn)) * 128'(q2), -56);
        for (int i = 0; i < 3; i++) begin
            am = scale_mag(128'(k) * 128'(mag(d[i])), sh);
            t = scale_mag(128'(3 * mag(dn[i])) * 128'(c), -30);
            u = v[i] - (((dn[i] < 0) != (pn < 0)) ? -$signed(t) : $signed(t));
            jm = scale_mag(128'(k) * 128'(mag(u)), sh);
            acc_run[i] = add_sat(acc_run[i], d[i] < 0 ? -$signed(am) : $signed(am));
            jerk_run[i] = add_sat(jerk_run[i], u < 0 ? -$signed(jm) : $signed(jm));
        end
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_item it;
        t_sums w;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                tgt_pos[i] <= 0; tgt_vel[i] <= 0; acc_run[i] = 0; jerk_run[i] = 0;
            end
            tgt_idx <= 0;
            sums_q.delete();
            o_errors = 0;
            o_results = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_POS_X, REG_POS_Y, REG_POS_Z:
                        tgt_pos[i_cfg_idx] <= 64'(signed'(i_cfg_data));
                    REG_VEL_X, REG_VEL_Y, REG_VEL_Z:
                        tgt_vel[i_cfg_idx - REG_VEL_X] <= 64'(signed'(i_cfg_data));
                    REG_INDEX: tgt_idx <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (i_src.valid && i_src.ready) begin
                it.mass = i_src.source_mass;
                it.pos = {i_src.source_pos_z, i_src.source_pos_y, i_src.source_pos_x};
                it.vel = {i_src.source_vel_z, i_src.source_vel_y, i_src.source_vel_x};
                it.idx = i_src.source_index;
                it.last = i_src.last_source;
                if (it.idx != tgt_idx) add_gravity(it);
                if (it.last) begin
                    for (int i = 0; i < 3; i++) begin
                        w.accel[i] = acc_run[i]; w.jerk[i] = jerk_run[i];
                        acc_run[i] = 0; jerk_run[i] = 0;
                    end
                    sums_q.push_back(w);
                end
            end
            if (i_res.valid && i_res.ready) begin
                o_results++;
                if (sums_q.size() == 0) begin
                    report("unexpected result beat", i_res.accel_x, 0);
                end else begin
                    w = sums_q.pop_front();
                    if (i_res.accel_x !== w.accel[0]) report("accel_x", i_res.accel_x, w.accel[0]);
                    if (i_res.accel_y !== w.accel[1]) report("accel_y", i_res.accel_y, w.accel[1]);
                    if (i_res.accel_z !== w.accel[2]) report("accel_z", i_res.accel_z, w.accel[2]);
                    if (i_res.jerk_x !== w.jerk[0]) report("jerk_x", i_res.jerk_x, w.jerk[0]);
                    if (i_res.jerk_y !== w.jerk[1]) report("jerk_y", i_res.jerk_y, w.jerk[1]);
                    if (i_res.jerk_z !== w.jerk[2]) report("jerk_z", i_res.jerk_z, w.jerk[2]);
                end
            end
        end
        o_pending = sums_q.size();
    end
endmodule

### verif/nbody_accel_jerk_accumulator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbody_accel_jerk_accumulator_top_tb
// drives target settings and source beats, a checker predicts every result
// ----------------------------------------------------------------------------
module nbody_accel_jerk_accumulator_top_tb;
    import nbaj_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = REG_POS_X;
    logic [31:0] i_cfg_data = 0;
    int          errors, pending, results;
    int          src_idle_pct = 0, res_idle_pct = 0;
    bit          hold_res = 0;
    int          beats = 0;

    nbaj_src_if src ();
    nbaj_res_if res ();

    nbody_accel_jerk_accumulator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_src(src.sink), .o_res(res.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    nbaj_sums_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_src(src), .i_res(res),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // receiver: random stalls, or a long hold-off while the sender keeps going
    always @(negedge i_clk) begin
        res.ready <= !hold_res && ($urandom_range(99) >= res_idle_pct);
    end

    initial begin
        src.valid = 0; src.source_mass = 0; src.source_pos_x = 0;
        src.source_pos_y = 0; src.source_pos_z = 0; src.source_vel_x = 0;
        src.source_vel_y = 0; src.source_vel_z = 0; src.source_index = 0;
        src.last_source = 0; res.ready = 0;
    end

    // one register write at the falling edge
    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        @(negedge i_clk);
    endtask

    // wait for every expected result, then let an in-flight source finish
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    // random coordinate: mostly modest, sometimes full range
    function automatic logic [31:0] coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'(signed'($urandom_range(2000)) - 1000) <<< 16;
            default: return 32'($urandom_range(65535 * 64)) - 32'(65535 * 32);
        endcase
    endfunction

    // the block is never ready in the cycle after a beat, so the gap costs nothing
    task automatic send(logic [31:0] m, logic [31:0] px, logic [31:0] py,
                        logic [31:0] pz, logic [31:0] vx, logic [31:0] vy,
                        logic [31:0] vz, logic [9:0] idx, logic last);
        while ($urandom_range(99) < src_idle_pct) @(negedge i_clk);
        src.valid <= 1; src.source_mass <= m; src.source_pos_x <= px;
        src.source_pos_y <= py; src.source_pos_z <= pz; src.source_vel_x <= vx;
        src.source_vel_y <= vy; src.source_vel_z <= vz; src.source_index <= idx;
        src.last_source <= last;
        @(posedge i_clk);
        while (!src.ready) @(posedge i_clk);
        beats++;
        @(negedge i_clk);
        src.valid <= 0;
        @(negedge i_clk);
    endtask

    task automatic random_target();
        for (int r = REG_POS_X; r <= REG_VEL_Z; r++)
            write_reg(t_reg_idx'(r), $urandom_range(1) ? coord() : $urandom());
        write_reg(REG_INDEX, $urandom_range(1023));
    endtask

    // runs of random sources, each closed by a last beat
    task automatic random_runs(int n);
        int k, len;
        k = 0;
        while (k < n) begin
            len = $urandom_range(5) == 0 ? 1 : $urandom_range(12, 2);
            for (int j = 0; j < len; j++, k++)
                send($urandom_range(3) == 0 ? $urandom() : $urandom_range(1 << 20),
                     coord(), coord(), coord(), coord(), coord(), coord(),
                     $urandom_range(7) == 0 ? chk.tgt_idx : 10'($urandom_range(1023)),
                     j == len - 1);
        end
    endtask

    initial begin
        logic [31:0] mx;
        mx = 32'hffff_ffff;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: reset target, extremes, same index, zero distance
        send(32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0, 0, 10'd1, 1);
        send(mx, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
             32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 10'h3ff, 0);
        send(mx, 32'h0000_0001, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0, 10'd2, 0);
        send(mx, 0, 0, 32'hffff_ffff, 32'h8000_0000, 0, 0, 10'd3, 1);
        send(mx, 0, 0, 0, 32'h1234_0000, 0, 0, 10'd5, 0);           // zero distance
        send(mx, 32'h10_0000, 0, 0, 0, 0, 0, 10'd0, 1);             // same index
        send(mx, 32'h10_0000, 0, 0, 0, 0, 0, 10'd0, 1);             // skipped last
        send(0, 32'h20_0000, 32'h5_0000, 0, 32'h1_0000, 0, 0, 10'd9, 1);
        drain();
        write_reg(REG_POS_X, 32'h8000_0000); write_reg(REG_POS_Y, 32'h7fff_ffff);
        write_reg(REG_POS_Z, 32'h8000_0000); write_reg(REG_VEL_X, 32'h7fff_ffff);
        write_reg(REG_VEL_Y, 32'h8000_0000); write_reg(REG_VEL_Z, 32'h7fff_ffff);
        write_reg(REG_INDEX, 10'h3ff);
        i_cfg_we <= 1; i_cfg_idx <= 3'd7; i_cfg_data <= $urandom();  // unused index
        @(negedge i_clk);
        i_cfg_we <= 0;
        for (int j = 0; j < 6; j++)
            send(mx, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 10'(j), j == 5);
        send(mx, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 10'h3ff, 1);
        send(mx, 32'h8000_0001, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 10'h3fe, 1);
        drain();

        // receiver holds off long while sources keep coming
        hold_res = 1;
        fork
            begin repeat (3000) @(negedge i_clk); hold_res = 0; end
            for (int j = 0; j < 10; j++) send(1 << 16, coord(), coord(), coord(),
                                              coord(), coord(), coord(), 10'(j + 1), 1);
        join
        drain();

        for (int p = 0; p < 3; p++) begin
            src_idle_pct = p == 0 ? 18 : (p == 1 ? 87 : 0);
            res_idle_pct = p == 0 ? 87 : (p == 1 ? 18 : 0);
            for (int s = 0; s < 4; s++) begin
                random_target();
                random_runs(p == 1 ? 100 : 150);
                drain();
            end
        end
        write_reg(REG_POS_X, 0); write_reg(REG_POS_Y, 0); write_reg(REG_POS_Z, 0);
        write_reg(REG_VEL_X, 0); write_reg(REG_VEL_Y, 0); write_reg(REG_VEL_Z, 0);
        write_reg(REG_INDEX, 0);
        random_runs(100);
        drain();

        $display("covered %0d source beats and %0d result beats over several targets",
                 beats, results);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

### nbody_accel_jerk_accumulator_top.f
hdl/nbaj_pkg.sv
hdl/nbaj_src_if.sv
hdl/nbaj_res_if.sv
hdl/nbaj_mac.sv
hdl/nbaj_core.sv
hdl/nbody_accel_jerk_accumulator_top.sv
verif/nbaj_sums_checker.sv
verif/nbody_accel_jerk_accumulator_top_tb.sv
